// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/edfs_pkg.sv -----
// ----------------------------------------------------------------------------
// EDF slot scheduler package
// Sizes, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package edfs_pkg;

    localparam int TASKS     = 4;
    localparam int TIME_W    = 16;
    localparam int IDX_W     = $clog2(TASKS);
    localparam int CNT_W     = $clog2(TASKS + 1);
    localparam int NWORDS    = 4;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int USE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TASKS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_FIRST   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LAST    = CFG_IDX_W'(NWORDS);

    localparam logic [USE_W-1:0]  USE_RESET  = USE_W'(1);
    localparam logic [WORD_W-1:0] WORD_RESET = WORD_W'(32'h0001_0000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } edfs_state_t;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [IDX_W-1:0]  task_idx_t;

endpackage

// ----- rtl/core/edfs_req_if.sv -----
// ----------------------------------------------------------------------------
// EDF slot scheduler request channel
// One request per time slot, carrying the restart flag.
// ----------------------------------------------------------------------------
interface edfs_req_if;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);

endinterface

// ----- rtl/core/edfs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// EDF slot scheduler response channel
// One response per slot: granted task, default flag and miss status.
// ----------------------------------------------------------------------------
interface edfs_rsp_if;

    logic       valid;
    logic       ready;
    logic [1:0] chosen_task;
    logic       by_default;
    logic       infeasible;
    logic [1:0] missed_task;

    modport source (output valid, output chosen_task, output by_default,
                    output infeasible, output missed_task, input ready);
    modport sink (input valid, input chosen_task, input by_default,
                  input infeasible, input missed_task, output ready);

endinterface

// ----- rtl/core/edf_slot_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// EDF slot scheduler unit
// Grants each time slot to a periodic task by earliest deadline first.
// ----------------------------------------------------------------------------
// Each request on req is one slot tick; restart clears all task state first.
// Each request yields exactly one response on rsp with the granted task, the
// default flag, the sticky infeasible flag and the lowest task that missed.
// Tasks are configured through cfg_we, cfg_index and cfg_data while idle:
// index 0 is the number of tasks in use, indexes 1 to 4 the task words.
// A request is taken only while the sequencer is idle. It then walks the
// task table one entry per cycle, releasing, checking for misses and
// comparing deadlines in a single shared compare unit, then finishes by
// loading the response register; a new request is taken only once the
// sequencer is back in idle, so one slot is through before the next starts.
// The response register holds its value while the receiver stalls; the
// sequencer waits in its finish step until the register is free.
// Reset clears all task state, the infeasible flag and the configuration
// to one task with period 1 and budget 0.
// ----------------------------------------------------------------------------
module edf_slot_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    edfs_req_if.sink                       req,
    edfs_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [edfs_pkg::WORD_W-1:0]    cfg_data
);
    import edfs_pkg::*;
    `include "assert_macros.svh"

    edfs_state_t state_reg, state_next;

    logic [USE_W-1:0]  tasks_in_use_reg;
    logic [WORD_W-1:0] task_word_reg [NWORDS];

    time_t budget_left_reg [TASKS];
    time_t deadline_reg    [TASKS];
    logic  failed_reg;

    task_idx_t scan_idx_reg;
    logic      restart_reg;
    logic      any_miss_reg, any_miss_next;
    task_idx_t missed_reg, missed_next;
    logic      found_reg, found_next;
    task_idx_t best_reg, best_next;
    time_t     best_d_reg, best_d_next;
    time_t     best_b_reg, best_b_next;

    logic       rsp_valid_reg;
    logic [1:0] rsp_chosen_reg;
    logic       rsp_default_reg;
    logic       rsp_infeasible_reg;
    logic [1:0] rsp_missed_reg;

    logic req_fire;
    logic scan_last;
    logic load_out;

    logic [CNT_W-1:0]  n_eff;
    logic              active;
    logic [WORD_W-1:0] word;
    time_t             period;
    time_t             cfg_budget;
    time_t             b_cur;
    time_t             d_cur;
    logic              release_now;
    time_t             b_new;
    time_t             d_new;
    logic              better;

    assign req_fire  = req.valid && req.ready;
    assign scan_last = (scan_idx_reg == task_idx_t'(TASKS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_FINISH: load_out  = !rsp_valid_reg || rsp.ready;
            default:
            begin
                req.ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // Shared per-task step: release, miss check and deadline compare.
    always_comb
    begin
        if (tasks_in_use_reg == USE_W'(0))
        begin
            n_eff = CNT_W'(1);
        end
        else if (tasks_in_use_reg > USE_W'(TASKS))
        begin
            n_eff = CNT_W'(TASKS);
        end
        else
        begin
            n_eff = CNT_W'(tasks_in_use_reg);
        end

        active     = CNT_W'(scan_idx_reg) < n_eff;
        word       = task_word_reg[scan_idx_reg];
        period     = (word[31:16] == 16'd0) ? TIME_W'(1) : word[31:16];
        cfg_budget = word[15:0];
        b_cur      = restart_reg ? '0 : budget_left_reg[scan_idx_reg];
        d_cur      = restart_reg ? '0 : deadline_reg[scan_idx_reg];

        release_now = (d_cur == '0);
        b_new       = release_now ? cfg_budget : b_cur;
        d_new       = release_now ? period : d_cur;
        better      = active && (b_new != '0) && (!found_reg || d_new < best_d_reg);

        any_miss_next = any_miss_reg;
        missed_next   = missed_reg;
        if (active && release_now && (b_cur != '0) && !any_miss_reg)
        begin
            any_miss_next = 1'b1;
            missed_next   = scan_idx_reg;
        end

        found_next  = found_reg;
        best_next   = best_reg;
        best_d_next = best_d_reg;
        best_b_next = best_b_reg;
        if (better)
        begin
            found_next  = 1'b1;
            best_next   = scan_idx_reg;
            best_d_next = d_new;
            best_b_next = b_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tasks_in_use_reg <= USE_RESET;
            for (int i = 0; i < NWORDS; i++)
            begin
                task_word_reg[i] <= WORD_RESET;
            end
            for (int i = 0; i < TASKS; i++)
            begin
                budget_left_reg[i] <= '0;
                deadline_reg[i]    <= '0;
            end
            failed_reg    <= 1'b0;
            scan_idx_reg  <= '0;
            restart_reg   <= 1'b0;
            any_miss_reg  <= 1'b0;
            missed_reg    <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == CFG_TASKS_IN_USE)
                begin
                    tasks_in_use_reg <= cfg_data[USE_W-1:0];
                end
                else if (cfg_index >= CFG_WORD_FIRST && cfg_index <= CFG_WORD_LAST)
                begin
                    task_word_reg[IDX_W'(cfg_index - CFG_WORD_FIRST)] <= cfg_data;
                end
            end

            if (req_fire)
            begin
                scan_idx_reg <= '0;
                restart_reg  <= req.restart;
                any_miss_reg <= 1'b0;
                missed_reg   <= '0;
                found_reg    <= 1'b0;
                best_reg     <= '0;
                if (req.restart)
                begin
                    failed_reg <= 1'b0;
                end
            end

            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + task_idx_t'(1);
                any_miss_reg <= any_miss_next;
                missed_reg   <= missed_next;
                found_reg    <= found_next;
                best_reg     <= best_next;
                if (active)
                begin
                    budget_left_reg[scan_idx_reg] <= b_new;
                    deadline_reg[scan_idx_reg]    <= d_new - TIME_W'(1);
                end
                else
                begin
                    budget_left_reg[scan_idx_reg] <= '0;
                    deadline_reg[scan_idx_reg]    <= '0;
                end
            end

            if (load_out)
            begin
                if (found_reg)
                begin
                    budget_left_reg[best_reg] <= best_b_reg - TIME_W'(1);
                end
                failed_reg    <= failed_reg || any_miss_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            best_d_reg <= best_d_next;
            best_b_reg <= best_b_next;
        end
        if (load_out)
        begin
            rsp_chosen_reg     <= found_reg ? 2'(best_reg) : 2'd0;
            rsp_default_reg    <= !found_reg;
            rsp_infeasible_reg <= failed_reg || any_miss_reg;
            rsp_missed_reg     <= 2'(missed_reg);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.chosen_task = rsp_chosen_reg;
    assign rsp.by_default  = rsp_default_reg;
    assign rsp.infeasible  = rsp_infeasible_reg;
    assign rsp.missed_task = rsp_missed_reg;

    `ASSERT_CLK(a_accept_starts_scan, clk, rst_n, req_fire |=> (state_reg == ST_SCAN && scan_idx_reg == '0), "accepted request did not start a scan")
    `ASSERT_CLK(a_default_is_task0, clk, rst_n, (rsp.valid && rsp.by_default) |-> (rsp.chosen_task == 2'd0), "default grant not given to task 0")
    `ASSERT_CLK(a_miss_sets_flag, clk, rst_n, (rsp.valid && rsp.missed_task != 2'd0) |-> rsp.infeasible, "miss reported without infeasible flag")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// EDF slot scheduler unit testbench
// Drives slot requests with random restart flags through several task tables,
// predicts every grant in a local earliest-deadline-first model and checks
// each response field, with random stalls on both channels and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import edfs_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] chosen_task;
        logic       by_default;
        logic       infeasible;
        logic [1:0] missed_task;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    edfs_req_if req_ch ();
    edfs_rsp_if rsp_ch ();

    edf_slot_scheduler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [USE_W-1:0] use_cnt;
    logic [WORD_W-1:0] word_q [NWORDS];
    time_t budget_left_q [TASKS];
    time_t deadline_cnt [TASKS];
    logic failed_q;

    bit tick_q [$];
    grant_t expected_grants [$];
    int mismatch_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_req = 1'b0;
    bit stall_seen = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic grant_t edf_schedule_slot(input logic restart);
        int unsigned n;
        logic [WORD_W-1:0] w;
        time_t period;
        time_t budget;
        time_t best_d;
        logic any_miss;
        logic found;
        task_idx_t missed;
        task_idx_t best;
        grant_t g;
        any_miss = 1'b0;
        found = 1'b0;
        missed = '0;
        best = '0;
        best_d = '0;
        if (restart)
        begin
            for (int j = 0; j < TASKS; j++)
            begin
                budget_left_q[j] = '0;
                deadline_cnt[j] = '0;
            end
            failed_q = 1'b0;
        end
        n = use_cnt;
        if (n < 1)
            n = 1;
        if (n > TASKS)
            n = TASKS;
        for (int j = 0; j < TASKS; j++)
        begin
            if (j >= n)
            begin
                budget_left_q[j] = '0;
                deadline_cnt[j] = '0;
            end
        end
        for (int j = 0; j < n; j++)
        begin
            w = (j < NWORDS) ? word_q[j] : WORD_RESET;
            period = ((w >> 16) > {TIME_W{1'b1}}) ? {TIME_W{1'b1}} : time_t'(w >> 16);
            budget = ((w & 32'hFFFF) > {TIME_W{1'b1}}) ? {TIME_W{1'b1}}
                                                      : time_t'(w & 32'hFFFF);
            if (period == 0)
                period = 1;
            if (deadline_cnt[j] == 0)
            begin
                if (budget_left_q[j] != 0 && !any_miss)
                begin
                    any_miss = 1'b1;
                    missed = task_idx_t'(j);
                end
                budget_left_q[j] = budget;
                deadline_cnt[j] = period;
            end
            if (budget_left_q[j] != 0 && (!found || deadline_cnt[j] < best_d))
            begin
                found = 1'b1;
                best = task_idx_t'(j);
                best_d = deadline_cnt[j];
            end
        end
        if (any_miss)
            failed_q = 1'b1;
        if (found)
            budget_left_q[best] = budget_left_q[best] - 1'b1;
        else
            best = '0;
        for (int j = 0; j < n; j++)
            deadline_cnt[j] = deadline_cnt[j] - 1'b1;
        g.chosen_task = best[1:0];
        g.by_default = !found;
        g.infeasible = failed_q;
        g.missed_task = missed[1:0];
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_TASKS_IN_USE)
            use_cnt = data[USE_W-1:0];
        else if (idx >= CFG_WORD_FIRST && idx <= CFG_WORD_LAST)
            word_q[IDX_W'(idx - CFG_WORD_FIRST)] = data;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_q.size() != 0 || req_ch.valid || expected_grants.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.restart <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_grants.push_back(edf_schedule_slot(req_ch.restart));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.restart <= tick_q.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        grant_t e;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected response count", 0, 1);
                else
                begin
                    e = expected_grants.pop_front();
                    if (rsp_ch.chosen_task !== e.chosen_task)
                        report_mismatch("chosen_task", e.chosen_task, rsp_ch.chosen_task);
                    if (rsp_ch.by_default !== e.by_default)
                        report_mismatch("by_default", e.by_default, rsp_ch.by_default);
                    if (rsp_ch.infeasible !== e.infeasible)
                        report_mismatch("infeasible", e.infeasible, rsp_ch.infeasible);
                    if (rsp_ch.missed_task !== e.missed_task)
                        report_mismatch("missed_task", e.missed_task, rsp_ch.missed_task);
                end
            end
            if (stall_req && !stall_seen)
            begin
                stall_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** edf_slot_scheduler_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        time_t period;
        time_t budget;
        int n_items;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.restart = 1'b0;
        rsp_ch.ready = 1'b0;
        use_cnt = USE_RESET;
        for (int j = 0; j < NWORDS; j++)
            word_q[j] = WORD_RESET;
        for (int j = 0; j < TASKS; j++)
        begin
            budget_left_q[j] = '0;
            deadline_cnt[j] = '0;
        end
        failed_q = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 60;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset table: task 0 alone with no budget, so every slot is a default grant.
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        wait_drained();

        // Full table: a zero period, a budget above its period and the widest task.
        write_reg(CFG_TASKS_IN_USE, WORD_W'(4));
        write_reg(CFG_WORD_FIRST, {16'd4, 16'd1});
        write_reg(CFG_IDX_W'(CFG_WORD_FIRST + 1), {16'd2, 16'd3});
        write_reg(CFG_IDX_W'(CFG_WORD_FIRST + 2), {16'd0, 16'd0});
        write_reg(CFG_WORD_LAST, {16'hFFFF, 16'hFFFF});
        cfg_we <= 1'b0;
        for (int i = 0; i < 9; i++)
            tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        wait_drained();

        // Task counts of zero and above the table size, then shrinking to two tasks.
        write_reg(CFG_TASKS_IN_USE, WORD_W'(0));
        cfg_we <= 1'b0;
        for (int i = 0; i < 3; i++)
            tick_q.push_back(1'b0);
        wait_drained();
        write_reg(CFG_TASKS_IN_USE, WORD_W'(7));
        cfg_we <= 1'b0;
        for (int i = 0; i < 3; i++)
            tick_q.push_back(1'b0);
        wait_drained();
        write_reg(CFG_TASKS_IN_USE, WORD_W'(2));
        cfg_we <= 1'b0;
        for (int i = 0; i < 3; i++)
            tick_q.push_back(1'b0);
        wait_drained();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 60 : 0;
            recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 22 : 0;
            for (int ph = 0; ph < 5; ph++)
            begin
                case ($urandom_range(7))
                    0: write_reg(CFG_TASKS_IN_USE, WORD_W'(0));
                    1: write_reg(CFG_TASKS_IN_USE, WORD_W'($urandom_range(5, 7)));
                    default: write_reg(CFG_TASKS_IN_USE, WORD_W'($urandom_range(1, 4)));
                endcase
                for (int j = 0; j < NWORDS; j++)
                begin
                    case ($urandom_range(9))
                        0: period = '0;
                        1: period = '1;
                        2: period = time_t'($urandom);
                        default: period = time_t'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(9))
                        0: budget = '0;
                        1: budget = '1;
                        2: budget = time_t'($urandom);
                        default: budget = time_t'($urandom_range(0, period + 1));
                    endcase
                    write_reg(CFG_IDX_W'(CFG_WORD_FIRST + j), {period, budget});
                end
                cfg_we <= 1'b0;
                n_items = $urandom_range(22, 32);
                tick_q.push_back(1'($urandom_range(1)));
                for (int i = 1; i < n_items; i++)
                    tick_q.push_back($urandom_range(99) < 3);
                if (mode == 2 && ph == 0)
                    stall_req <= 1'b1;
                wait_drained();
            end
        end

        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("** edf_slot_scheduler_unit: PASSED **");
        else
            $display("** edf_slot_scheduler_unit: FAILED **");
        $finish;
    end

endmodule
